[hdl/bale_pkg.sv]
// shared types and codes for the bounded array list engine
`default_nettype none
package bale_pkg;

  localparam int DATA_W  = 32;
  localparam int TOTAL_W = 36;
  localparam int OP_W    = 4;
  localparam int POS_W   = 4;
  localparam int FIDX_W  = 4;
  localparam int LCNT_W  = 5;
  localparam int STAT_W  = 3;

  typedef logic signed [DATA_W-1:0] data_t;

  // request codes
  localparam logic [OP_W-1:0] OP_APPEND  = 4'd0;
  localparam logic [OP_W-1:0] OP_INSERT  = 4'd1;
  localparam logic [OP_W-1:0] OP_DELETE  = 4'd2;
  localparam logic [OP_W-1:0] OP_SEARCH  = 4'd3;
  localparam logic [OP_W-1:0] OP_SWAPF   = 4'd4;
  localparam logic [OP_W-1:0] OP_GET     = 4'd5;
  localparam logic [OP_W-1:0] OP_SET     = 4'd6;
  localparam logic [OP_W-1:0] OP_BSEARCH = 4'd7;
  localparam logic [OP_W-1:0] OP_SINSERT = 4'd8;
  localparam logic [OP_W-1:0] OP_REVERSE = 4'd9;
  localparam logic [OP_W-1:0] OP_ROTL    = 4'd10;
  localparam logic [OP_W-1:0] OP_ROTR    = 4'd11;
  localparam logic [OP_W-1:0] OP_SHL     = 4'd12;
  localparam logic [OP_W-1:0] OP_SHR     = 4'd13;
  localparam logic [OP_W-1:0] OP_PART    = 4'd14;
  localparam logic [OP_W-1:0] OP_STATS   = 4'd15;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STAT_W-1:0] ST_BAD_POS  = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd4;

endpackage
`default_nettype wire

[hdl/bale_div.sv]
// iterative signed divider, one quotient bit per cycle, positive divisor
`default_nettype none
module bale_div import bale_pkg::*; #(
  parameter int DW = 37,
  parameter int VW = 5
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic signed [DW-1:0] dividend_i,
  input  wire logic        [VW-1:0] divisor_i,
  output logic                      done_o,
  output data_t                     quotient_o
);

  localparam int CNTW = $clog2(DW + 1);

  logic            busy_q, done_q, neg_q;
  logic [CNTW-1:0] cnt_q;
  logic [DW-1:0]   quo_q;
  logic [VW-1:0]   rem_q, dsr_q;
  logic [VW:0]     trial;
  logic            fits;
  logic [DW-1:0]   quo_s;

  assign trial = {rem_q, quo_q[DW-1]};
  assign fits  = trial >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNTW'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNTW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[DW-1];
      quo_q <= dividend_i[DW-1] ? DW'(-dividend_i) : DW'(dividend_i);
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? VW'(trial - {1'b0, dsr_q}) : trial[VW-1:0];
      quo_q <= {quo_q[DW-2:0], fits};
    end
  end

  assign quo_s      = neg_q ? -quo_q : quo_q;
  assign done_o     = done_q;
  assign quotient_o = quo_s[DATA_W-1:0];

endmodule
`default_nettype wire

[hdl/bounded_array_list_engine.sv]
// top level: request sequencer, entry memory and result register
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   request | in_valid_i/in_ready_o, req_type, position,| in
//           | value                                     |
//   result  | out_valid_o/out_ready_i, status .. count  | out
//
// one word in, one word out; the sequencer owns a single memory port pair
// and walks entries one at a time, with a registered read for each element
// reverse/partition: each swap reads both entries, then writes both back
// stats: one pass over the entries, then the divider for the average
// reset empties the list at once; entries are never read beyond the count
// a new word is taken only when idle; a waiting result holds in its register
`default_nettype none
module bounded_array_list_engine import bale_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [OP_W-1:0]           req_type_i,
  input  wire logic [POS_W-1:0]          position_i,
  input  wire logic signed [DATA_W-1:0]  value_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [STAT_W-1:0]              status_o,
  output logic [FIDX_W-1:0]              found_index_o,
  output logic signed [DATA_W-1:0]       read_value_o,
  output logic signed [DATA_W-1:0]       max_value_o,
  output logic signed [DATA_W-1:0]       min_value_o,
  output logic signed [TOTAL_W-1:0]      total_o,
  output logic signed [DATA_W-1:0]       average_o,
  output logic                           is_sorted_o,
  output logic [LCNT_W-1:0]              live_count_o
);

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int PW   = (CW > POS_W) ? CW : POS_W;
  localparam int SUMW = (DATA_W + CW > TOTAL_W + 1) ? DATA_W + CW : TOTAL_W + 1;

  // sequencer states
  localparam logic [4:0] S_IDLE = 5'd0,  S_DISP = 5'd1,  S_UP   = 5'd2,  S_UP_D = 5'd3;
  localparam logic [4:0] S_PRED = 5'd4,  S_DN   = 5'd5,  S_DN_D = 5'd6,  S_SR   = 5'd7;
  localparam logic [4:0] S_SR_D = 5'd8,  S_GETD = 5'd9,  S_BS   = 5'd10, S_BS_D = 5'd11;
  localparam logic [4:0] S_RV   = 5'd12, S_PT   = 5'd13, S_PA   = 5'd14, S_PA_D = 5'd15;
  localparam logic [4:0] S_PB   = 5'd16, S_PB_D = 5'd17, S_PC   = 5'd18, S_SWA  = 5'd19;
  localparam logic [4:0] S_SWB  = 5'd20, S_SWC  = 5'd21, S_SWD  = 5'd22, S_ST   = 5'd23;
  localparam logic [4:0] S_ST_D = 5'd24, S_DIV  = 5'd25, S_FIN  = 5'd26;

  logic [4:0]             state_q, state_d;
  logic [OP_W-1:0]        op_q;
  logic [POS_W-1:0]       pos_q;
  data_t                  val_q;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic [CW-1:0]          idx_q, idx_d, bnd_q, bnd_d;
  logic signed [CW:0]     lo_q, lo_d, hi_q, hi_d;
  data_t                  tmp_q, tmp_d, prev_q, prev_d;
  logic [STAT_W-1:0]      stat_q, stat_d;
  logic [CW-1:0]          fidx_q, fidx_d;
  data_t                  rd_q, rd_d, mx_q, mx_d, mn_q, mn_d, avg_q, avg_d;
  logic signed [SUMW-1:0] sum_q, sum_d;
  logic                   srt_q, srt_d;

  // entry memory
  data_t                  mem [CAPACITY];
  data_t                  rdata_q;
  logic [AW-1:0]          raddr, waddr;
  logic                   we;
  data_t                  wdata;

  logic                   ovalid_q;
  logic                   accept, full, empty, div_start, div_done;
  data_t                  div_quo;
  logic [PW-1:0]          pos_w, n_w;
  logic signed [CW:0]     n_s, idx_s;
  logic signed [CW+1:0]   mid_sum;
  logic [CW:0]            mid;
  logic [CW-1:0]          idx_p1, idx_m1;
  logic                   sat;

  assign accept  = in_valid_i && in_ready_o;
  assign full    = cnt_q == CW'(CAPACITY);
  assign empty   = cnt_q == '0;
  assign pos_w   = PW'(pos_q);
  assign n_w     = PW'(cnt_q);
  assign n_s     = $signed({1'b0, cnt_q});
  assign idx_s   = $signed({1'b0, idx_q});
  assign idx_p1  = idx_q + CW'(1);
  assign idx_m1  = idx_q - CW'(1);
  assign mid_sum = {lo_q[CW], lo_q} + {hi_q[CW], hi_q};
  assign mid     = mid_sum[CW+1:1];
  assign sat     = !((&sum_q[SUMW-1:TOTAL_W-1]) || !(|sum_q[SUMW-1:TOTAL_W-1]));

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  bale_div #(.DW(SUMW), .VW(CW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_d),
    .divisor_i  (cnt_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    bnd_d     = bnd_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    tmp_d     = tmp_q;
    prev_d    = prev_q;
    stat_d    = stat_q;
    fidx_d    = fidx_q;
    rd_d      = rd_q;
    mx_d      = mx_q;
    mn_d      = mn_q;
    avg_d     = avg_q;
    sum_d     = sum_q;
    srt_d     = srt_q;
    raddr     = '0;
    waddr     = '0;
    we        = 1'b0;
    wdata     = val_q;
    div_start = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          stat_d  = ST_OK;
          fidx_d  = '0;
          rd_d    = '0;
          mx_d    = '0;
          mn_d    = '0;
          avg_d   = '0;
          sum_d   = '0;
          srt_d   = 1'b0;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        state_d = S_FIN;
        if (empty && !(op_q inside {OP_APPEND, OP_INSERT, OP_SINSERT})) begin
          stat_d = ST_EMPTY;
        end else begin
          case (op_q)
            OP_APPEND: begin
              if (full) stat_d = ST_FULL;
              else begin
                we    = 1'b1;
                waddr = cnt_q[AW-1:0];
                cnt_d = cnt_q + CW'(1);
              end
            end
            OP_INSERT, OP_SINSERT: begin
              if (full) stat_d = ST_FULL;
              else if (op_q == OP_INSERT && pos_w > n_w) stat_d = ST_BAD_POS;
              else begin
                idx_d   = cnt_q;
                bnd_d   = (op_q == OP_INSERT) ? CW'(pos_q) : '0;
                tmp_d   = val_q;
                state_d = S_UP;
              end
            end
            OP_DELETE, OP_GET, OP_SET: begin
              if (pos_w >= n_w) stat_d = ST_BAD_POS;
              else if (op_q == OP_SET) begin
                we    = 1'b1;
                waddr = AW'(pos_q);
              end else begin
                raddr   = AW'(pos_q);
                state_d = (op_q == OP_GET) ? S_GETD : S_PRED;
              end
            end
            OP_SEARCH, OP_SWAPF: begin
              stat_d  = ST_NOTFOUND;
              idx_d   = '0;
              state_d = S_SR;
            end
            OP_BSEARCH: begin
              stat_d  = ST_NOTFOUND;
              lo_d    = '0;
              hi_d    = n_s - 2'sd1;
              state_d = S_BS;
            end
            OP_REVERSE, OP_PART: begin
              lo_d    = '0;
              hi_d    = n_s - 2'sd1;
              state_d = (op_q == OP_REVERSE) ? S_RV : S_PT;
            end
            OP_ROTL, OP_SHL: begin
              raddr   = '0;
              state_d = S_PRED;
            end
            OP_ROTR, OP_SHR: begin
              raddr   = AW'(cnt_q - CW'(1));
              state_d = S_PRED;
            end
            default: begin
              idx_d   = '0;
              srt_d   = 1'b1;
              state_d = S_ST;
            end
          endcase
        end
      end
      // shift entries up toward the tail, then drop tmp into the hole
      S_UP: begin
        if (idx_q > bnd_q) begin
          raddr   = idx_m1[AW-1:0];
          state_d = S_UP_D;
        end else begin
          we    = 1'b1;
          waddr = idx_q[AW-1:0];
          wdata = tmp_q;
          if (op_q == OP_INSERT || op_q == OP_SINSERT) cnt_d = cnt_q + CW'(1);
          state_d = S_FIN;
        end
      end
      S_UP_D: begin
        we    = 1'b1;
        waddr = idx_q[AW-1:0];
        if (op_q == OP_SINSERT && !(rdata_q > val_q)) begin
          cnt_d   = cnt_q + CW'(1);
          state_d = S_FIN;
        end else begin
          wdata   = rdata_q;
          idx_d   = idx_m1;
          state_d = S_UP;
        end
      end
      S_PRED: begin
        case (op_q)
          OP_DELETE: begin
            rd_d    = rdata_q;
            idx_d   = CW'(pos_q);
            state_d = S_DN;
          end
          OP_ROTL, OP_SHL: begin
            tmp_d   = (op_q == OP_ROTL) ? rdata_q : '0;
            idx_d   = '0;
            state_d = S_DN;
          end
          default: begin
            tmp_d   = (op_q == OP_ROTR) ? rdata_q : '0;
            idx_d   = cnt_q - CW'(1);
            bnd_d   = '0;
            state_d = S_UP;
          end
        endcase
      end
      // shift entries down toward the head
      S_DN: begin
        if (idx_p1 < cnt_q) begin
          raddr   = idx_p1[AW-1:0];
          state_d = S_DN_D;
        end else begin
          if (op_q == OP_DELETE) cnt_d = cnt_q - CW'(1);
          else begin
            we    = 1'b1;
            waddr = idx_q[AW-1:0];
            wdata = tmp_q;
          end
          state_d = S_FIN;
        end
      end
      S_DN_D: begin
        we      = 1'b1;
        waddr   = idx_q[AW-1:0];
        wdata   = rdata_q;
        idx_d   = idx_p1;
        state_d = S_DN;
      end
      S_SR: begin
        if (idx_q < cnt_q) begin
          raddr   = idx_q[AW-1:0];
          state_d = S_SR_D;
        end else state_d = S_FIN;
      end
      S_SR_D: begin
        if (rdata_q == val_q) begin
          stat_d = ST_OK;
          fidx_d = idx_q;
          if (op_q == OP_SWAPF && idx_q != '0) begin
            lo_d    = idx_s;
            hi_d    = '0;
            state_d = S_SWA;
          end else state_d = S_FIN;
        end else begin
          idx_d   = idx_p1;
          state_d = S_SR;
        end
      end
      S_GETD: begin
        rd_d    = rdata_q;
        state_d = S_FIN;
      end
      S_BS: begin
        if (lo_q <= hi_q) begin
          raddr   = mid[AW-1:0];
          idx_d   = mid[CW-1:0];
          state_d = S_BS_D;
        end else state_d = S_FIN;
      end
      S_BS_D: begin
        if (rdata_q == val_q) begin
          stat_d  = ST_OK;
          fidx_d  = idx_q;
          state_d = S_FIN;
        end else begin
          if (val_q > rdata_q) lo_d = idx_s + 2'sd1;
          else hi_d = idx_s - 2'sd1;
          state_d = S_BS;
        end
      end
      S_RV: state_d = (lo_q < hi_q) ? S_SWA : S_FIN;
      S_PT: state_d = (lo_q < hi_q) ? S_PA : S_FIN;
      // partition: skip negatives from the head, non-negatives from the tail
      S_PA: begin
        if (lo_q < n_s) begin
          raddr   = lo_q[AW-1:0];
          state_d = S_PA_D;
        end else state_d = S_PB;
      end
      S_PA_D: begin
        if (rdata_q < 0) begin
          lo_d    = lo_q + 2'sd1;
          state_d = S_PA;
        end else state_d = S_PB;
      end
      S_PB: begin
        if (!hi_q[CW]) begin
          raddr   = hi_q[AW-1:0];
          state_d = S_PB_D;
        end else state_d = S_PC;
      end
      S_PB_D: begin
        if (rdata_q >= 0) begin
          hi_d    = hi_q - 2'sd1;
          state_d = S_PB;
        end else state_d = S_PC;
      end
      S_PC: state_d = (lo_q < hi_q) ? S_SWA : S_PT;
      // exchange entries at lo and hi
      S_SWA: begin
        raddr   = lo_q[AW-1:0];
        state_d = S_SWB;
      end
      S_SWB: begin
        tmp_d   = rdata_q;
        raddr   = hi_q[AW-1:0];
        state_d = S_SWC;
      end
      S_SWC: begin
        we      = 1'b1;
        waddr   = lo_q[AW-1:0];
        wdata   = rdata_q;
        state_d = S_SWD;
      end
      S_SWD: begin
        we    = 1'b1;
        waddr = hi_q[AW-1:0];
        wdata = tmp_q;
        case (op_q)
          OP_REVERSE: begin
            lo_d    = lo_q + 2'sd1;
            hi_d    = hi_q - 2'sd1;
            state_d = S_RV;
          end
          OP_PART: state_d = S_PT;
          default: state_d = S_FIN;
        endcase
      end
      S_ST: begin
        if (idx_q < cnt_q) begin
          raddr   = idx_q[AW-1:0];
          state_d = S_ST_D;
        end else begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end
      end
      S_ST_D: begin
        if (idx_q == '0) begin
          mx_d  = rdata_q;
          mn_d  = rdata_q;
        end else begin
          if (rdata_q > mx_q) mx_d = rdata_q;
          if (rdata_q < mn_q) mn_d = rdata_q;
          if (prev_q > rdata_q) srt_d = 1'b0;
        end
        sum_d   = sum_q + SUMW'(rdata_q);
        prev_d  = rdata_q;
        idx_d   = idx_p1;
        state_d = S_ST;
      end
      S_DIV: begin
        if (div_done) begin
          avg_d   = div_quo;
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!ovalid_q || out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (state_q == S_FIN && (!ovalid_q || out_ready_i)) ovalid_q <= 1'b1;
      else if (out_ready_i) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= req_type_i;
      pos_q <= position_i;
      val_q <= value_i;
    end
    idx_q  <= idx_d;
    bnd_q  <= bnd_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    tmp_q  <= tmp_d;
    prev_q <= prev_d;
    stat_q <= stat_d;
    fidx_q <= fidx_d;
    rd_q   <= rd_d;
    mx_q   <= mx_d;
    mn_q   <= mn_d;
    avg_q  <= avg_d;
    sum_q  <= sum_d;
    srt_q  <= srt_d;
    // result word register
    if (state_q == S_FIN && (!ovalid_q || out_ready_i)) begin
      status_o      <= stat_q;
      found_index_o <= FIDX_W'(fidx_q);
      read_value_o  <= rd_q;
      max_value_o   <= mx_q;
      min_value_o   <= mn_q;
      total_o       <= sat ? (sum_q[SUMW-1] ? {1'b1, {(TOTAL_W-1){1'b0}}}
                                            : {1'b0, {(TOTAL_W-1){1'b1}}})
                           : sum_q[TOTAL_W-1:0];
      average_o     <= avg_q;
      is_sorted_o   <= srt_q;
      live_count_o  <= LCNT_W'(cnt_q);
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = ovalid_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY))
    else $error("live count above capacity");

  a_accept_disp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_DISP)
    else $error("accepted word not dispatched");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> cnt_q != '0)
    else $error("divide with empty list");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != $past(cnt_q) |-> ($past(state_q) == S_DISP || $past(state_q) == S_UP ||
                               $past(state_q) == S_UP_D || $past(state_q) == S_DN))
    else $error("count changed outside a list update");

  a_waddr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (CW'(waddr) < CW'(CAPACITY)))
    else $error("write beyond capacity");

endmodule
`default_nettype wire
